### hdl/pba_pkg.sv
// Package with shared types, constants and codes of the partitioned bump allocator.
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

  // Fixed field widths of the item and register interfaces.
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned BYTES_W    = 24;
  localparam int unsigned ALIGN_W    = 4;
  localparam int unsigned SLOT_W     = 32;
  localparam int unsigned OFFSET_W   = 24;
  localparam int unsigned CAP_W      = 24;
  localparam int unsigned FRAME_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // The shared divider takes the widest dividend (the frame slot).
  localparam int unsigned DIV_W = SLOT_W;

  // Defaults of the top-level parameters.
  localparam int unsigned DEF_OFFSET_BITS = 24;
  localparam int unsigned DEF_MAX_FRAMES  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_REWIND = 2'd1,
    MODE_SLOT   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_CAPACITY = 2'd1,
    CFG_FRAMES   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_FIT,
    ST_SLOT_START,
    ST_SLOT_WAIT,
    ST_SLOT_SET,
    ST_SIZE_START,
    ST_SIZE_WAIT
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BYTES_W-1:0] byte_count;
    logic [ALIGN_W-1:0] align_log2;
    logic [SLOT_W-1:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic                granted;
    logic [OFFSET_W-1:0] offset;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rewind;
    logic align;
    logic commit;
    logic div_start;
    logic div_sel_slot;
    logic size_load;
    logic slot_mul;
    logic slot_set;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### hdl/partitioned_bump_allocator.sv
// Top level of the partitioned bump allocator: controller, datapath and ports.
`timescale 1ns / 1ps
`default_nettype none
// The block hands out byte offsets from a staging region of capacity_bytes
// bytes that is split into equal partitions, one for each frame in flight.
// An allocate item rounds the head up to 2**align_log2, and if the request
// is non-zero, the block is enabled and the request ends inside the current
// partition, it returns the aligned offset with granted set and moves the
// head past the request; otherwise it returns granted and offset both zero.
// A rewind item moves the head back to the partition start, and a slot item
// selects partition slot_index modulo the frame count and rewinds to it.
// Only allocate items produce a result item. An allocate item is accepted,
// aligned and fit-checked in turn, the fit check waiting for a free result
// register; a rewind item completes when accepted, and a slot item runs the
// shared one-bit-per-cycle divider that forms the 32-bit modulo, followed
// by one multiply and one add. Each write to a defined register rewinds the
// block to the first partition and starts a division of the capacity by
// the frame count; input items are held off until it ends.
// A frame count of zero counts as one, and counts above MAX_FRAMES saturate.
module partitioned_bump_allocator #(
  parameter int unsigned OFFSET_BITS = pba_pkg::DEF_OFFSET_BITS,
  parameter int unsigned MAX_FRAMES  = pba_pkg::DEF_MAX_FRAMES
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire pba_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output pba_pkg::out_item_t                  out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import pba_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller decodes the mode of an offered item itself so that a
  // rewind completes in the cycle it is accepted.
  pba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_item_i.mode),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the registers, the allocator state, the shared
  // divider and the result register that decouples the output side.
  pba_dp #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_FRAMES  (MAX_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // An accepted allocate item keeps the input closed while it is worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_item_i.mode == MODE_ALLOC)) |=> !in_ready_o)
    else $error("input ready right after an allocate item");

  // A new result appears only after the controller commits an allocation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("result valid without a commit");

  // A refused allocation always reports offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.granted) |-> (out_item_o.offset == '0))
    else $error("refused result with non-zero offset");

  // A register write starts the partition size computation and blocks items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && ((cfg_idx_i == CFG_ENABLE) || (cfg_idx_i == CFG_CAPACITY) ||
     (cfg_idx_i == CFG_FRAMES))) |=> !in_ready_o)
    else $error("input ready while partition size is recomputed");
`endif

endmodule
`default_nettype wire

### hdl/pba_div.sv
// Radix-2 restoring divider giving quotient and remainder, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pba_div #(
  parameter int unsigned DVD_W = 32,
  parameter int unsigned DVS_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quotient_o,
  output logic [DVS_W-1:0]      remainder_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

### hdl/pba_dp.sv
// Datapath of the allocator: registers, head arithmetic, partition math and result register.
`timescale 1ns / 1ps
`default_nettype none
module pba_dp #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned MAX_FRAMES  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pba_pkg::in_item_t             in_item_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire pba_pkg::cmd_t                 cmd_i,
  output pba_pkg::status_t                   status_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output pba_pkg::out_item_t                 out_item_o
);

  import pba_pkg::*;

  localparam int unsigned FB   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned EW   = (FB > FRAME_W) ? FB : FRAME_W;
  localparam int unsigned MAXW = (OFFSET_BITS > CAP_W) ? OFFSET_BITS : CAP_W;
  // Wide enough for an aligned head plus a full request without wrapping.
  localparam int unsigned SW   = MAXW + 2;
  localparam int unsigned XW   = (OFFSET_BITS > DIV_W) ? OFFSET_BITS : DIV_W;

  // Configuration registers.
  logic                   enable_q;
  logic [CAP_W-1:0]       capacity_q;
  logic [FRAME_W-1:0]     frames_q;

  // Allocator state.
  logic [OFFSET_BITS-1:0] head_q;
  logic [OFFSET_BITS-1:0] part_start_q;
  logic [OFFSET_BITS-1:0] part_end_q;
  logic [OFFSET_BITS-1:0] size_q;
  logic [OFFSET_BITS-1:0] prod_q;
  logic [SW-1:0]          aligned_q;
  in_item_t               item_q;

  logic                   out_valid_q;
  out_item_t              out_item_q;

  logic                   cfg_hit;
  logic [FB-1:0]          eff_frames;
  logic [EW-1:0]          frames_ext;
  logic [DIV_W-1:0]       div_dividend;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quo;
  logic [FB-1:0]          div_rem;
  logic [XW-1:0]          quo_ext;
  logic [SW-1:0]          align_mask;
  logic [SW-1:0]          aligned_d;
  logic [SW-1:0]          req_end;
  logic                   fits;
  logic [SW-1:0]          ofs_ext;
  logic [OFFSET_BITS+FB-1:0] prod_full;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_ENABLE) ||
                   (cfg_idx_i == CFG_CAPACITY) || (cfg_idx_i == CFG_FRAMES));

  // Zero frames counts as one, and the count saturates at the partition limit.
  assign frames_ext = EW'(frames_q);
  always_comb begin
    if (frames_q == '0) begin
      eff_frames = FB'(1);
    end else if (int'(frames_q) > int'(MAX_FRAMES)) begin
      eff_frames = FB'(MAX_FRAMES);
    end else begin
      eff_frames = frames_ext[FB-1:0];
    end
  end

  assign div_dividend = cmd_i.div_sel_slot ? item_q.slot_index : DIV_W'(capacity_q);

  pba_div #(
    .DVD_W (DIV_W),
    .DVS_W (FB)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (eff_frames),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign quo_ext = XW'(div_quo);

  // Round the head up to the requested power-of-two alignment.
  assign align_mask = (SW'(1) << item_q.align_log2) - SW'(1);
  assign aligned_d  = (SW'(head_q) + align_mask) & ~align_mask;

  assign req_end = aligned_q + SW'(item_q.byte_count);
  assign fits    = enable_q && (item_q.byte_count != '0) && (req_end <= SW'(part_end_q));
  assign ofs_ext = SW'(aligned_q[OFFSET_BITS-1:0]);

  assign prod_full = size_q * div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      capacity_q   <= '0;
      frames_q     <= FRAME_W'(1);
      head_q       <= '0;
      part_start_q <= '0;
      part_end_q   <= '0;
      size_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_hit) begin
        case (cfg_idx_i)
          CFG_ENABLE:   enable_q   <= cfg_data_i[0];
          CFG_CAPACITY: capacity_q <= cfg_data_i[CAP_W-1:0];
          CFG_FRAMES:   frames_q   <= cfg_data_i[FRAME_W-1:0];
          default:      ;
        endcase
        head_q       <= '0;
        part_start_q <= '0;
      end else if (cmd_i.rewind) begin
        head_q <= part_start_q;
      end else if (cmd_i.commit && fits) begin
        head_q <= req_end[OFFSET_BITS-1:0];
      end else if (cmd_i.size_load) begin
        size_q     <= quo_ext[OFFSET_BITS-1:0];
        part_end_q <= quo_ext[OFFSET_BITS-1:0];
      end else if (cmd_i.slot_set) begin
        part_start_q <= prod_q;
        part_end_q   <= prod_q + size_q;
        head_q       <= prod_q;
      end

      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.align) begin
      aligned_q <= aligned_d;
    end
    if (cmd_i.slot_mul) begin
      prod_q <= prod_full[OFFSET_BITS-1:0];
    end
    if (cmd_i.commit) begin
      out_item_q.granted <= fits;
      out_item_q.offset  <= fits ? ofs_ext[OFFSET_W-1:0] : '0;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;

endmodule
`default_nettype wire

### hdl/pba_ctrl.sv
// Controller state machine that sequences the allocator datapath.
`timescale 1ns / 1ps
`default_nettype none
module pba_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [pba_pkg::MODE_W-1:0]    in_mode_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire pba_pkg::status_t              status_i,
  output logic                               in_ready_o,
  output pba_pkg::cmd_t                      cmd_o
);

  import pba_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   cfg_hit;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_ENABLE) ||
                   (cfg_idx_i == CFG_CAPACITY) || (cfg_idx_i == CFG_FRAMES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !cfg_we_i;
        if (in_valid_i && !cfg_we_i) begin
          case (in_mode_i)
            MODE_ALLOC: begin
              cmd_o.capture = 1'b1;
              state_d       = ST_ALIGN;
            end
            MODE_REWIND: begin
              cmd_o.rewind = 1'b1;
            end
            MODE_SLOT: begin
              cmd_o.capture = 1'b1;
              state_d       = ST_SLOT_START;
            end
            default: ;
          endcase
        end
      end
      ST_ALIGN: begin
        cmd_o.align = 1'b1;
        state_d     = ST_FIT;
      end
      ST_FIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SLOT_START: begin
        cmd_o.div_start    = 1'b1;
        cmd_o.div_sel_slot = 1'b1;
        state_d            = ST_SLOT_WAIT;
      end
      ST_SLOT_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.slot_mul = 1'b1;
          state_d        = ST_SLOT_SET;
        end
      end
      ST_SLOT_SET: begin
        cmd_o.slot_set = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SIZE_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_SIZE_WAIT;
      end
      ST_SIZE_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.size_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write rewinds to the first partition and recomputes its size.
    if (cfg_hit) begin
      state_d = ST_SIZE_START;
    end
  end

endmodule
`default_nettype wire

### verif/pba_checker.sv
// Checker for the partitioned bump allocator: predicts each allocation outcome and compares.
`timescale 1ns / 1ps
module pba_checker
  import pba_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire in_item_t              in_item_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire out_item_t             out_item_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o,
  output int unsigned                results_o,
  output int unsigned                grants_o
);

  localparam longint unsigned OFS_MASK = (64'd1 << OFFSET_W) - 64'd1;

  // Shadow registers and allocator state.
  logic                en_q;
  logic [CAP_W-1:0]    cap_q;
  logic [FRAME_W-1:0]  frames_q;
  logic [OFFSET_W-1:0] head_q;
  logic [OFFSET_W-1:0] start_q;
  logic [OFFSET_W-1:0] end_q;

  // Outcomes of accepted allocations, oldest first.
  out_item_t   grant_q[$];
  out_item_t   want;
  int unsigned errors;
  int unsigned results;
  int unsigned grants;

  initial begin
    errors  = 0;
    results = 0;
    grants  = 0;
  end

  function automatic longint unsigned live_frames();
    longint unsigned f;
    f = 64'(frames_q);
    if (f == 0) f = 1;
    if (f > DEF_MAX_FRAMES) f = DEF_MAX_FRAMES;
    return f;
  endfunction

  function automatic longint unsigned slice_size();
    longint unsigned c;
    c = 64'(cap_q);
    return (c / live_frames()) & OFS_MASK;
  endfunction

  task automatic back_to_first_slice();
    head_q  = '0;
    start_q = '0;
    end_q   = OFFSET_W'(slice_size());
  endtask

  task automatic report(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENABLE: begin
        en_q = data[0];
        back_to_first_slice();
      end
      CFG_CAPACITY: begin
        cap_q = data[CAP_W-1:0];
        back_to_first_slice();
      end
      CFG_FRAMES: begin
        frames_q = data[FRAME_W-1:0];
        back_to_first_slice();
      end
      default: ;
    endcase
  endtask

  // Works out what one accepted item does to the state and queues the outcome of an allocation.
  task automatic forecast_grant(input in_item_t it);
    longint unsigned align;
    longint unsigned aligned;
    longint unsigned need;
    longint unsigned size;
    longint unsigned slot;
    longint unsigned h;
    out_item_t       r;
    case (it.mode)
      MODE_ALLOC: begin
        h       = 64'(head_q);
        align   = 64'd1 << it.align_log2;
        aligned = (h + align - 64'd1) & ~(align - 64'd1);
        need    = aligned + 64'(it.byte_count);
        r       = '0;
        if (en_q && it.byte_count != '0 && need <= 64'(end_q)) begin
          head_q    = OFFSET_W'(need & OFS_MASK);
          r.granted = 1'b1;
          r.offset  = OFFSET_W'(aligned & OFS_MASK);
        end
        grant_q.push_back(r);
      end
      MODE_REWIND: head_q = start_q;
      MODE_SLOT: begin
        size    = slice_size();
        slot    = 64'(it.slot_index) % live_frames();
        start_q = OFFSET_W'((size * slot) & OFS_MASK);
        end_q   = OFFSET_W'((64'(start_q) + size) & OFS_MASK);
        head_q  = start_q;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      en_q     = 1'b0;
      cap_q    = '0;
      frames_q = FRAME_W'(1);
      back_to_first_slice();
      grant_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (grant_q.size() == 0) begin
          report($sformatf("result with nothing outstanding: granted %0b offset %0d",
                           out_item_i.granted, out_item_i.offset));
        end else begin
          want = grant_q.pop_front();
          if (out_item_i.granted !== want.granted)
            report($sformatf("granted is %0b, predicted %0b", out_item_i.granted, want.granted));
          if (out_item_i.offset !== want.offset)
            report($sformatf("offset is %0d, predicted %0d", out_item_i.offset, want.offset));
          if (want.granted) grants++;
        end
      end
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_i) forecast_grant(in_item_i);
    end
    fail_count_o <= errors;
    pending_o    <= grant_q.size();
    results_o    <= results;
    grants_o     <= grants;
  end

endmodule

### verif/partitioned_bump_allocator_tb.sv
// Top of the partitioned bump allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module partitioned_bump_allocator_tb;
  import pba_pkg::*;

  // Cycles let pass before a register write so that a slot selection or a
  // capacity division still running inside the block has finished.
  localparam int unsigned SETTLE       = 48;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 65;

  // The spare mode code and the spare register index are legal on the wires
  // and must be ignored by the block.
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned grants;

  // Stimulus-side copy of the capacity and frame count, used only to size
  // requests so that allocation bursts both fit and overflow.
  logic [CAP_W-1:0]   sh_cap;
  logic [FRAME_W-1:0] sh_frames;

  // When calm is set neither side inserts gaps or stalls.
  bit calm;

  int unsigned n_alloc;
  int unsigned n_rewind;
  int unsigned n_slot;
  int unsigned n_spare;
  int unsigned n_writes;

  partitioned_bump_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  pba_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .grants_o     (grants)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run (every item a slot selection
  // with the longest gap and stall, plus all register phases).
  initial begin
    #2_000_000;
    $display("partitioned_bump_allocator test failed");
    $finish;
  end

  // Result side: before each item the receiver holds ready low for a random
  // number of cycles, then keeps it high until a result is taken.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(7, 0);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Builds one item; fields that the mode does not use still carry data.
  function automatic in_item_t pack_item(input logic [MODE_W-1:0] mode,
                                         input logic [BYTES_W-1:0] bytes,
                                         input logic [ALIGN_W-1:0] align,
                                         input logic [SLOT_W-1:0] slot);
    in_item_t it;
    it.mode       = mode;
    it.byte_count = bytes;
    it.align_log2 = align;
    it.slot_index = slot;
    return it;
  endfunction

  // Size of one partition as the current settings give it.
  function automatic int unsigned slice_bytes();
    int unsigned f;
    f = 32'(sh_frames);
    if (f == 0) f = 1;
    if (f > DEF_MAX_FRAMES) f = DEF_MAX_FRAMES;
    return 32'(sh_cap) / f;
  endfunction

  // Request sizes: mostly a fraction of a partition, so a burst fills it and
  // then overflows; now and then zero, a whole partition or any 24-bit value.
  function automatic logic [BYTES_W-1:0] pick_bytes();
    int unsigned part;
    int unsigned r;
    part = slice_bytes();
    r    = $urandom_range(19, 0);
    if (r == 0) return '0;
    if (r == 1) return BYTES_W'($urandom);
    if (r == 2) return (part == 0) ? BYTES_W'(1) : BYTES_W'(part);
    return BYTES_W'($urandom_range(part / 3 + 1, 1));
  endfunction

  // Mostly modest alignments; one in five spans the whole 4-bit field.
  function automatic logic [ALIGN_W-1:0] pick_align();
    if ($urandom_range(4, 0) == 0) return ALIGN_W'($urandom_range(15, 0));
    return ALIGN_W'($urandom_range(5, 0));
  endfunction

  // Slot indexes: half small, half anywhere in the 32-bit range.
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(1, 0) == 0) return SLOT_W'($urandom_range(20, 0));
    return SLOT_W'($urandom);
  endfunction

  // Offers one item after a random gap and returns at the edge where it is
  // accepted, with valid still high so that the next item can follow at once.
  task automatic send(input in_item_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(7, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    case (it.mode)
      MODE_ALLOC:  n_alloc++;
      MODE_REWIND: n_rewind++;
      MODE_SLOT:   n_slot++;
      default:     n_spare++;
    endcase
  endtask

  // Drops valid and waits until every allocation outcome has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Register writes happen only on an idle block; the pause covers work that
  // produces no result (slot selection, the division after a prior write).
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    repeat (SETTLE) @(posedge clk_i);
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_writes++;
  endtask

  // Writes all three registers; unused upper data bits carry random values,
  // which the block must ignore.
  task automatic configure(input logic en, input logic [CAP_W-1:0] cap,
                           input logic [FRAME_W-1:0] frames);
    logic [CFG_DATA_W-1:0] word;
    drain();
    word    = CFG_DATA_W'($urandom);
    word[0] = en;
    write_reg(CFG_ENABLE, word);
    write_reg(CFG_CAPACITY, cap);
    word            = CFG_DATA_W'($urandom);
    word[FRAME_W-1:0] = frames;
    write_reg(CFG_FRAMES, word);
    sh_cap    = cap;
    sh_frames = frames;
  endtask

  initial begin
    in_item_t         it;
    int unsigned      goal;
    int unsigned      burst;
    logic             en;
    logic [CAP_W-1:0] cap;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    sh_cap     = '0;
    sh_frames  = FRAME_W'(1);
    calm       = 1'b0;
    n_alloc    = 0;
    n_rewind   = 0;
    n_slot     = 0;
    n_spare    = 0;
    n_writes   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With 1000 bytes in four partitions each partition holds
    // 250 bytes: zero-size refusal, alignment, overflow, an exact fill, a
    // rewind, slot selection with a slot far above the frame count, and the
    // spare mode, which must give no result.
    configure(1'b1, CAP_W'(1000), FRAME_W'(4));
    send(pack_item(MODE_ALLOC, BYTES_W'(0), ALIGN_W'(0), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(1), ALIGN_W'(0), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(10), ALIGN_W'(3), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(300), ALIGN_W'(0), $urandom));
    send(pack_item(MODE_ALLOC, 24'hFFFFFF, ALIGN_W'(15), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(232), ALIGN_W'(0), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(1), ALIGN_W'(0), $urandom));
    send(pack_item(MODE_REWIND, BYTES_W'($urandom), ALIGN_W'($urandom), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(16), ALIGN_W'(12), $urandom));
    send(pack_item(MODE_SLOT, BYTES_W'($urandom), ALIGN_W'($urandom), SLOT_W'(3)));
    send(pack_item(MODE_ALLOC, BYTES_W'(5), ALIGN_W'(4), $urandom));
    send(pack_item(MODE_SLOT, BYTES_W'($urandom), ALIGN_W'($urandom), 32'hFFFFFFFF));
    send(pack_item(MODE_SPARE, BYTES_W'($urandom), ALIGN_W'($urandom), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(250), ALIGN_W'(0), $urandom));

    // Disabled: allocations are refused while rewind and slot still act.
    configure(1'b0, CAP_W'(1000), FRAME_W'(4));
    send(pack_item(MODE_SLOT, BYTES_W'($urandom), ALIGN_W'($urandom), SLOT_W'(1)));
    send(pack_item(MODE_ALLOC, BYTES_W'(4), ALIGN_W'(0), $urandom));
    send(pack_item(MODE_REWIND, BYTES_W'($urandom), ALIGN_W'($urandom), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(8), ALIGN_W'(2), $urandom));

    // Full capacity, last of sixteen partitions: the head is pushed close to
    // the top so that the largest alignment carries past 24 bits.
    configure(1'b1, CAP_W'(24'hFFFFFF), FRAME_W'(16));
    send(pack_item(MODE_SLOT, BYTES_W'($urandom), ALIGN_W'($urandom), SLOT_W'(15)));
    send(pack_item(MODE_ALLOC, BYTES_W'(1048000), ALIGN_W'(0), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(1), ALIGN_W'(15), $urandom));
    send(pack_item(MODE_ALLOC, BYTES_W'(1), ALIGN_W'(0), $urandom));

    // Random part, one phase per register setting. The first phases take the
    // extremes: full capacity with the frame count at 16 and far above it,
    // zero capacity, frame count zero, disabled, and a one-byte region.
    goal = n_alloc + n_rewind + n_slot;
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      calm = (ph % 3 == 2);
      case (ph)
        0: configure(1'b1, CAP_W'(24'hFFFFFF), FRAME_W'(16));
        1: configure(1'b1, CAP_W'(24'hFFFFFF), FRAME_W'(31));
        2: configure(1'b1, CAP_W'(0), FRAME_W'(3));
        3: begin
          configure(1'b1, CAP_W'(4095), FRAME_W'(0));
          // The spare register index must leave every setting alone.
          write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        end
        4: configure(1'b0, CAP_W'(50000), FRAME_W'(5));
        5: configure(1'b1, CAP_W'(1), FRAME_W'(1));
        default: begin
          en  = ($urandom_range(9, 0) != 0);
          cap = ($urandom_range(1, 0) == 0) ? CAP_W'($urandom_range(5000, 1))
                                            : CAP_W'($urandom);
          configure(en, cap, FRAME_W'($urandom_range(31, 0)));
        end
      endcase

      goal += PHASE_ITEMS;
      while (n_alloc + n_rewind + n_slot < goal) begin
        if ($urandom_range(99, 0) < 15) begin
          // Noise: any mode with every field random.
          send(pack_item(MODE_W'($urandom), BYTES_W'($urandom), ALIGN_W'($urandom),
                         $urandom));
        end else begin
          // A frame's worth of work: select a slot, allocate a burst, and
          // sometimes rewind and allocate again in the same partition.
          send(pack_item(MODE_SLOT, BYTES_W'($urandom), ALIGN_W'($urandom), pick_slot()));
          burst = $urandom_range(8, 1);
          repeat (burst) send(pack_item(MODE_ALLOC, pick_bytes(), pick_align(), $urandom));
          if ($urandom_range(2, 0) == 0) begin
            send(pack_item(MODE_REWIND, BYTES_W'($urandom), ALIGN_W'($urandom), $urandom));
            burst = $urandom_range(3, 1);
            repeat (burst) send(pack_item(MODE_ALLOC, pick_bytes(), pick_align(), $urandom));
          end
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d allocations (%0d granted), %0d rewinds, %0d slot selections",
             n_alloc, grants, n_rewind, n_slot);
    $display("and %0d spare-mode items over %0d register writes; %0d results compared.",
             n_spare, n_writes, results);
    if (fail_count == 0) begin
      $display("partitioned_bump_allocator test passed");
    end else begin
      $display("partitioned_bump_allocator test failed");
    end
    $finish;
  end

endmodule
